@@ hw/rtl/i2crm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and constants for the I2C register master
// Configuration reset values, register decode and the item/result words.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crm_pkg;

  localparam int unsigned PADDR_W = 3;

  // Register decode uses bit 2 of the byte address.
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [9:0] PHASE_TICKS_RST = 10'd35;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd30;

  typedef struct packed {
    logic [9:0] phase_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic       start_request;
    logic       operation;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       write_taken;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       error;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2crm_regs.sv @@
// ----------------------------------------------------------------------------
// i2crm_regs: configuration registers
// APB-style write and read access to the phase length and ack timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [i2crm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output i2crm_pkg::cfg_t                   cfg_o
);

  logic [9:0] phase_ticks_q;
  logic [7:0] ack_timeout_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2crm_pkg::PHASE_TICKS_RST;
      ack_timeout_q <= i2crm_pkg::ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        i2crm_pkg::REG_PHASE_TICKS: phase_ticks_q <= pwdata[9:0];
        i2crm_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2crm_pkg::REG_PHASE_TICKS: prdata = {22'd0, phase_ticks_q};
      i2crm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, ack_timeout_q};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg_o.phase_ticks = phase_ticks_q;
  assign cfg_o.ack_timeout = ack_timeout_q;

endmodule

`default_nettype wire

@@ hw/rtl/i2crm_core.sv @@
// ----------------------------------------------------------------------------
// i2crm_core: transaction sequencer
// Advances the bus sequence by one tick for each word and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire i2crm_pkg::cfg_t   cfg_i,
  input  wire i2crm_pkg::item_t  item_i,
  output i2crm_pkg::result_t     res_o
);

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_START_A   = 5'd1;
  localparam logic [4:0] ST_START_B   = 5'd2;
  localparam logic [4:0] ST_START_C   = 5'd3;
  localparam logic [4:0] ST_TX_LOW    = 5'd4;
  localparam logic [4:0] ST_TX_HIGH   = 5'd5;
  localparam logic [4:0] ST_TX_HOLD   = 5'd6;
  localparam logic [4:0] ST_ACK_LOW   = 5'd7;
  localparam logic [4:0] ST_ACK_HIGH  = 5'd8;
  localparam logic [4:0] ST_ACK_POLL  = 5'd9;
  localparam logic [4:0] ST_ACK_END   = 5'd10;
  localparam logic [4:0] ST_RX_LOW    = 5'd11;
  localparam logic [4:0] ST_RX_HIGH   = 5'd12;
  localparam logic [4:0] ST_RX_HOLD   = 5'd13;
  localparam logic [4:0] ST_MACK_LOW  = 5'd14;
  localparam logic [4:0] ST_MACK_HIGH = 5'd15;
  localparam logic [4:0] ST_MACK_END  = 5'd16;
  localparam logic [4:0] ST_STOP_A    = 5'd17;
  localparam logic [4:0] ST_STOP_B    = 5'd18;
  localparam logic [4:0] ST_STOP_C    = 5'd19;

  localparam logic [1:0] KIND_ADDR_W = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_ADDR_R = 2'd3;

  logic [4:0] step_q, step_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic [7:0] shift_q, shift_d;
  logic [9:0] delay_q, delay_d;
  logic [7:0] ack_wait_q, ack_wait_d;
  logic [6:0] held_addr_q, held_addr_d;
  logic [7:0] held_reg_q, held_reg_d;
  logic       held_op_q, held_op_d;
  logic [1:0] kind_q, kind_d;
  logic       err_flag_q, err_flag_d;

  logic [10:0] delay_inc;
  logic        phase_hit;
  logic [9:0]  delay_adv;
  logic [3:0]  bit_inc;
  logic [7:0]  bytes_dec;
  logic        tx_bit;
  logic        ack_bit;

  // Phase timer: a phase ends once the incremented count reaches the setting.
  assign delay_inc = {1'b0, delay_q} + 11'd1;
  assign phase_hit = delay_inc >= {1'b0, cfg_i.phase_ticks};
  assign delay_adv = phase_hit ? 10'd0 : delay_inc[9:0];
  assign bit_inc   = bit_cnt_q + 4'd1;
  assign bytes_dec = bytes_left_q - 8'd1;
  assign tx_bit    = shift_q[7];
  assign ack_bit   = (bytes_left_q == 8'd0);

  // Line levels follow the state held at the start of the tick.
  always_comb begin
    res_o             = '0;
    res_o.scl_release = 1'b1;
    res_o.sda_release = 1'b1;
    res_o.busy_res    = (step_q != ST_IDLE);
    case (step_q)
      ST_START_B: res_o.sda_release = 1'b0;
      ST_START_C, ST_STOP_A: begin
        res_o.scl_release = 1'b0;
        res_o.sda_release = 1'b0;
      end
      ST_TX_LOW, ST_TX_HOLD: begin
        res_o.scl_release = 1'b0;
        res_o.sda_release = tx_bit;
      end
      ST_TX_HIGH: res_o.sda_release = tx_bit;
      ST_ACK_LOW, ST_ACK_END, ST_RX_LOW, ST_RX_HOLD: res_o.scl_release = 1'b0;
      ST_MACK_LOW, ST_MACK_END: begin
        res_o.scl_release = 1'b0;
        res_o.sda_release = ack_bit;
      end
      ST_MACK_HIGH: res_o.sda_release = ack_bit;
      ST_STOP_B:    res_o.sda_release = 1'b0;
      default: ;
    endcase

    case (step_q)
      ST_ACK_END: begin
        if (phase_hit && kind_q != KIND_ADDR_W && kind_q != KIND_ADDR_R &&
            !(kind_q == KIND_REG && held_op_q) && bytes_left_q != 8'd0) begin
          res_o.write_taken = 1'b1;
        end
      end
      ST_RX_HOLD: begin
        if (phase_hit && bit_inc >= 4'd8) begin
          res_o.read_valid = 1'b1;
          res_o.read_data  = shift_q;
          res_o.read_last  = (bytes_dec == 8'd0);
        end
      end
      ST_STOP_C: begin
        if (phase_hit) begin
          res_o.done_res = 1'b1;
          res_o.error    = err_flag_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    step_d       = step_q;
    bit_cnt_d    = bit_cnt_q;
    bytes_left_d = bytes_left_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    ack_wait_d   = ack_wait_q;
    held_addr_d  = held_addr_q;
    held_reg_d   = held_reg_q;
    held_op_d    = held_op_q;
    kind_d       = kind_q;
    err_flag_d   = err_flag_q;

    case (step_q)
      ST_IDLE: begin
        if (item_i.start_request) begin
          held_addr_d  = item_i.slave_address;
          held_reg_d   = item_i.register_address;
          held_op_d    = item_i.operation;
          bytes_left_d = item_i.byte_count;
          err_flag_d   = 1'b0;
          delay_d      = 10'd0;
          shift_d      = {item_i.slave_address, 1'b0};
          kind_d       = KIND_ADDR_W;
          step_d       = ST_START_A;
        end
      end
      ST_START_A, ST_START_B, ST_TX_LOW, ST_TX_HIGH, ST_ACK_LOW, ST_RX_LOW,
      ST_MACK_LOW, ST_MACK_HIGH, ST_STOP_A, ST_STOP_B: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          step_d = step_q + 5'd1;
        end
      end
      ST_START_C: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          bit_cnt_d = 4'd0;
          step_d    = ST_TX_LOW;
        end
      end
      ST_TX_HOLD: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_inc;
          step_d    = (bit_inc >= 4'd8) ? ST_ACK_LOW : ST_TX_LOW;
        end
      end
      ST_ACK_HIGH: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          ack_wait_d = 8'd0;
          step_d     = ST_ACK_POLL;
        end
      end
      ST_ACK_POLL: begin
        delay_d = 10'd0;
        if (!item_i.sda_in) begin
          step_d = ST_ACK_END;
        end else if (ack_wait_q >= cfg_i.ack_timeout) begin
          err_flag_d = 1'b1;
          step_d     = ST_STOP_A;
        end else begin
          ack_wait_d = ack_wait_q + 8'd1;
        end
      end
      ST_ACK_END: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          if (kind_q == KIND_ADDR_W) begin
            shift_d   = held_reg_q;
            kind_d    = KIND_REG;
            bit_cnt_d = 4'd0;
            step_d    = ST_TX_LOW;
          end else if (kind_q == KIND_ADDR_R) begin
            if (bytes_left_q != 8'd0) begin
              bit_cnt_d = 4'd0;
              shift_d   = 8'd0;
              step_d    = ST_RX_LOW;
            end else begin
              step_d = ST_STOP_A;
            end
          end else if (kind_q == KIND_REG && held_op_q) begin
            // Register index sent: repeated start with the read address.
            shift_d = {held_addr_q, 1'b1};
            kind_d  = KIND_ADDR_R;
            step_d  = ST_START_A;
          end else if (bytes_left_q != 8'd0) begin
            bytes_left_d = bytes_dec;
            shift_d      = item_i.write_data;
            kind_d       = KIND_DATA;
            bit_cnt_d    = 4'd0;
            step_d       = ST_TX_LOW;
          end else begin
            step_d = ST_STOP_A;
          end
        end
      end
      ST_RX_HIGH: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          step_d  = ST_RX_HOLD;
        end
      end
      ST_RX_HOLD: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          bit_cnt_d = bit_inc;
          if (bit_inc >= 4'd8) begin
            bytes_left_d = bytes_dec;
            step_d       = ST_MACK_LOW;
          end else begin
            step_d = ST_RX_LOW;
          end
        end
      end
      ST_MACK_END: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          if (bytes_left_q != 8'd0) begin
            bit_cnt_d = 4'd0;
            shift_d   = 8'd0;
            step_d    = ST_RX_LOW;
          end else begin
            step_d = ST_STOP_A;
          end
        end
      end
      ST_STOP_C: begin
        delay_d = delay_adv;
        if (phase_hit) begin
          err_flag_d = 1'b0;
          step_d     = ST_IDLE;
        end
      end
      default: begin
        step_d  = ST_IDLE;
        delay_d = 10'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ST_IDLE;
      bit_cnt_q    <= 4'd0;
      bytes_left_q <= 8'd0;
      shift_q      <= 8'd0;
      delay_q      <= 10'd0;
      ack_wait_q   <= 8'd0;
      held_addr_q  <= 7'd0;
      held_reg_q   <= 8'd0;
      held_op_q    <= 1'b0;
      kind_q       <= KIND_ADDR_W;
      err_flag_q   <= 1'b0;
    end else if (step_i) begin
      step_q       <= step_d;
      bit_cnt_q    <= bit_cnt_d;
      bytes_left_q <= bytes_left_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      ack_wait_q   <= ack_wait_d;
      held_addr_q  <= held_addr_d;
      held_reg_q   <= held_reg_d;
      held_op_q    <= held_op_d;
      kind_q       <= kind_d;
      err_flag_q   <= err_flag_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2c_register_master_top.sv @@
// ----------------------------------------------------------------------------
// i2c_register_master_top: I2C master for register read and write transactions
// A word is held in the input register, then steps the sequencer, and its
// result is captured in the result register until it is taken.
// Throughput: one word per cycle unless the result channel stalls; the
// sequencer steps once per word. An input register and a result register
// part the two channels, so a word is taken while an earlier result
// still waits. Reset clears the handshake stages and the sequencer and loads
// the configuration defaults (35 ticks per phase, ack timeout of 30).
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_master_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [i2crm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          start_request_i,
  input  wire logic                          operation_i,
  input  wire logic [6:0]                    slave_address_i,
  input  wire logic [7:0]                    register_address_i,
  input  wire logic [7:0]                    byte_count_i,
  input  wire logic [7:0]                    write_data_i,
  input  wire logic                          sda_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               scl_release_o,
  output logic                               sda_release_o,
  output logic                               write_taken_o,
  output logic                               read_valid_o,
  output logic      [7:0]                    read_data_o,
  output logic                               read_last_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic                               error_o
);

  i2crm_pkg::cfg_t    cfg;
  i2crm_pkg::item_t   in_q;
  i2crm_pkg::result_t res;
  i2crm_pkg::result_t out_q;
  logic               in_vld_q;
  logic               out_vld_q;
  logic               advance;
  logic               in_take;

  i2crm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A held word steps the sequencer when the result register is free or drains.
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_take | (in_vld_q & ~advance);
      out_vld_q <= advance | (out_vld_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.start_request    <= start_request_i;
      in_q.operation        <= operation_i;
      in_q.slave_address    <= slave_address_i;
      in_q.register_address <= register_address_i;
      in_q.byte_count       <= byte_count_i;
      in_q.write_data       <= write_data_i;
      in_q.sda_in           <= sda_in_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  i2crm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .item_i (in_q),
    .res_o  (res)
  );

  assign out_valid_o   = out_vld_q;
  assign scl_release_o = out_q.scl_release;
  assign sda_release_o = out_q.sda_release;
  assign write_taken_o = out_q.write_taken;
  assign read_valid_o  = out_q.read_valid;
  assign read_data_o   = out_q.read_data;
  assign read_last_o   = out_q.read_last;
  assign busy_res_o    = out_q.busy_res;
  assign done_res_o    = out_q.done_res;
  assign error_o       = out_q.error;

endmodule

`default_nettype wire

@@ hw/rtl/i2crm_checker.sv @@
// ----------------------------------------------------------------------------
// i2crm_checker: port-level checks for the I2C register master
// Watches the result words on the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       scl_release_o,
  input wire logic       sda_release_o,
  input wire logic       write_taken_o,
  input wire logic       read_valid_o,
  input wire logic [7:0] read_data_o,
  input wire logic       read_last_o,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic       error_o
);

  // A finished transaction ends with both lines released during a busy tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o && scl_release_o && sda_release_o)
    else $error("done word without released lines or busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> done_res_o)
    else $error("error flagged outside the done word");

  // Read fields are quiet on words that carry no received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == 8'd0 && !read_last_o)
    else $error("read data or last set without read_valid");

  // A data byte is fetched only at the end of an ack, with SCL held low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_taken_o |-> !scl_release_o && sda_release_o && busy_res_o)
    else $error("write data taken outside an ack low phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

endmodule

bind i2c_register_master_top i2crm_checker u_checker (.*);

`default_nettype wire
